// ===== sv/numeric_literal_classifier_defines.svh =====
// ----------------------------------------------------------------------------
// Numeric literal classifier assertion macros
// Shared concurrent assertion forms for the classifier RTL.
// ----------------------------------------------------------------------------
`ifndef NUMERIC_LITERAL_CLASSIFIER_DEFINES_SVH
`define NUMERIC_LITERAL_CLASSIFIER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define NLC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define NLC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/nlc_pkg.sv =====
// ----------------------------------------------------------------------------
// Numeric literal classifier package
// Format codes, float dot-check phases, prefix kinds and character classes.
// ----------------------------------------------------------------------------
`default_nettype none

package nlc_pkg;

	typedef enum logic [2:0] {
		FMT_DECIMAL = 3'd0,
		FMT_OCTAL   = 3'd1,
		FMT_HEX     = 3'd2,
		FMT_BINARY  = 3'd3,
		FMT_FLOAT   = 3'd4,
		FMT_INVALID = 3'd5
	} fmt_t;

	typedef enum logic [2:0] {
		PH_IDLE       = 3'd0,
		PH_NEED_DIGIT = 3'd1,
		PH_DIGITS     = 3'd2,
		PH_AFTER_EXP  = 3'd3,
		PH_AFTER_SIGN = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		PK_NONE   = 2'd0,
		PK_HEX    = 2'd1,
		PK_BINARY = 2'd2,
		PK_OCTAL  = 2'd3
	} prefix_t;

	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_7     = 8'h37;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_F  = 8'h66;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_F  = 8'h46;
	localparam logic [7:0] CH_LC_X  = 8'h78;
	localparam logic [7:0] CH_UC_X  = 8'h58;
	localparam logic [7:0] CH_LC_B  = 8'h62;
	localparam logic [7:0] CH_UC_B  = 8'h42;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_LC_E  = 8'h65;
	localparam logic [7:0] CH_UC_E  = 8'h45;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;

	localparam logic [1:0] POS_MAX = 2'd2;

	function automatic logic is_dec(input logic [7:0] c);
		return (c inside {[CH_0:CH_9]});
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return (c inside {[CH_0:CH_9], [CH_LC_A:CH_LC_F], [CH_UC_A:CH_UC_F]});
	endfunction

endpackage

`default_nettype wire

// ===== sv/numeric_literal_classifier.sv =====
// ----------------------------------------------------------------------------
// Numeric literal classifier
// Streams a literal one character per transfer and reports its format code
// on the last character.
// ----------------------------------------------------------------------------
// One character is taken per clock cycle, back to back, while the input
// does not stall. A character is held in an input register while the
// classification flags update; on the last character the format code is
// loaded into the result register as that character leaves the input
// register, so a result passes through the input and then the result register.
// The input stalls only while that result register is full and stalled and
// the held character is itself a last character. Flags return to their reset
// values after each literal.
`default_nettype none
`include "numeric_literal_classifier_defines.svh"

module numeric_literal_classifier (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] char_code,
	input  wire logic       last_char,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [2:0]      format_code
);
	import nlc_pkg::*;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	logic [1:0] pos_q;
	logic       first_zero_q;
	prefix_t    prefix_q;
	logic       dot_q;
	logic       dec_ok_q;
	logic       oct_ok_q;
	logic       hex_ok_q;
	logic       bin_ok_q;
	logic       flt_ok_q;
	phase_t     phase_q;

	logic       out_valid_q;
	fmt_t       fmt_q;

	logic       advance;
	logic       proc;
	logic       d;
	logic       fail;
	logic       first_zero_n;
	prefix_t    prefix_n;
	logic       dot_n;
	logic       dec_ok_n;
	logic       oct_ok_n;
	logic       hex_ok_n;
	logic       bin_ok_n;
	logic       flt_ok_n;
	phase_t     phase_n;
	fmt_t       fmt_n;

	assign advance  = !valid_s1 || !last_s1 || !out_valid_q || !out_stall;
	assign proc     = valid_s1 && advance;
	assign in_stall = !advance;

	always_comb begin
		d            = is_dec(char_s1);
		fail         = 1'b0;
		first_zero_n = first_zero_q;
		prefix_n     = prefix_q;
		dec_ok_n     = dec_ok_q && d;
		oct_ok_n     = oct_ok_q;
		hex_ok_n     = hex_ok_q;
		bin_ok_n     = bin_ok_q;
		dot_n        = dot_q || (char_s1 == CH_DOT);

		if (pos_q == 2'd0) begin
			first_zero_n = (char_s1 == CH_0);
		end else if (pos_q == 2'd1 && first_zero_q) begin
			if (char_s1 == CH_LC_X || char_s1 == CH_UC_X) begin
				prefix_n = PK_HEX;
			end else if (char_s1 == CH_LC_B || char_s1 == CH_UC_B) begin
				prefix_n = PK_BINARY;
			end else begin
				prefix_n = PK_OCTAL;
			end
		end
		if (pos_q != 2'd0 && !(char_s1 inside {[CH_0:CH_7]}))
			oct_ok_n = 1'b0;
		if (pos_q == POS_MAX) begin
			if (!is_hex(char_s1))
				hex_ok_n = 1'b0;
			if (char_s1 != CH_0 && char_s1 != CH_1)
				bin_ok_n = 1'b0;
		end

		case (phase_q)
			PH_NEED_DIGIT: begin
				phase_n = d ? PH_DIGITS : PH_IDLE;
				fail    = !d;
			end
			PH_DIGITS: begin
				if (d)
					phase_n = PH_DIGITS;
				else if (char_s1 == CH_LC_E || char_s1 == CH_UC_E)
					phase_n = PH_AFTER_EXP;
				else if (char_s1 == CH_DOT)
					phase_n = PH_NEED_DIGIT;
				else
					phase_n = PH_IDLE;
			end
			PH_AFTER_EXP: begin
				if (char_s1 == CH_PLUS || char_s1 == CH_MINUS) begin
					phase_n = PH_AFTER_SIGN;
				end else begin
					phase_n = PH_IDLE;
					fail    = !d;
				end
			end
			PH_AFTER_SIGN: begin
				phase_n = PH_IDLE;
				fail    = !d;
			end
			default: begin
				phase_n = (char_s1 == CH_DOT) ? PH_NEED_DIGIT : PH_IDLE;
			end
		endcase

		flt_ok_n = flt_ok_q && !fail &&
			(d || char_s1 inside {CH_DOT, CH_PLUS, CH_MINUS, CH_LC_E, CH_UC_E});

		if (pos_q == 2'd0) begin
			fmt_n = d ? FMT_DECIMAL : FMT_INVALID;
		end else if (dot_n) begin
			fmt_n = (flt_ok_n && (phase_n == PH_IDLE || phase_n == PH_DIGITS)) ?
				FMT_FLOAT : FMT_INVALID;
		end else if (first_zero_n) begin
			case (prefix_n)
				PK_HEX:    fmt_n = hex_ok_n ? FMT_HEX : FMT_INVALID;
				PK_BINARY: fmt_n = bin_ok_n ? FMT_BINARY : FMT_INVALID;
				default:   fmt_n = oct_ok_n ? FMT_OCTAL : FMT_INVALID;
			endcase
		end else begin
			fmt_n = dec_ok_n ? FMT_DECIMAL : FMT_INVALID;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			char_s1 <= char_code;
			last_s1 <= last_char;
		end
	end

	// per-literal classification state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= 2'd0;
			first_zero_q <= 1'b0;
			prefix_q     <= PK_NONE;
			dot_q        <= 1'b0;
			dec_ok_q     <= 1'b1;
			oct_ok_q     <= 1'b1;
			hex_ok_q     <= 1'b1;
			bin_ok_q     <= 1'b1;
			flt_ok_q     <= 1'b1;
			phase_q      <= PH_IDLE;
		end else if (proc) begin
			if (last_s1) begin
				pos_q        <= 2'd0;
				first_zero_q <= 1'b0;
				prefix_q     <= PK_NONE;
				dot_q        <= 1'b0;
				dec_ok_q     <= 1'b1;
				oct_ok_q     <= 1'b1;
				hex_ok_q     <= 1'b1;
				bin_ok_q     <= 1'b1;
				flt_ok_q     <= 1'b1;
				phase_q      <= PH_IDLE;
			end else begin
				pos_q        <= (pos_q == POS_MAX) ? POS_MAX : pos_q + 2'd1;
				first_zero_q <= first_zero_n;
				prefix_q     <= prefix_n;
				dot_q        <= dot_n;
				dec_ok_q     <= dec_ok_n;
				oct_ok_q     <= oct_ok_n;
				hex_ok_q     <= hex_ok_n;
				bin_ok_q     <= bin_ok_n;
				flt_ok_q     <= flt_ok_n;
				phase_q      <= phase_n;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && last_s1)
			fmt_q <= fmt_n;
	end

	assign out_valid   = out_valid_q;
	assign format_code = fmt_q;

	`NLC_ASSERT_NEXT(a_last_loads_result, proc && last_s1, out_valid_q,
		"last character did not produce a result")
	`NLC_ASSERT_NEXT(a_state_cleared, proc && last_s1,
		pos_q == 2'd0 && phase_q == PH_IDLE && !dot_q,
		"classification state not cleared after literal")
	`NLC_ASSERT_NOW(a_stall_cause, in_stall,
		valid_s1 && last_s1 && out_valid_q && out_stall,
		"input stalled without a blocked result")
	`NLC_ASSERT_NOW(a_code_range, out_valid_q,
		fmt_q == FMT_DECIMAL || fmt_q == FMT_OCTAL || fmt_q == FMT_HEX ||
		fmt_q == FMT_BINARY || fmt_q == FMT_FLOAT || fmt_q == FMT_INVALID,
		"format code out of range")

endmodule

`default_nettype wire

// ===== tb/numeric_literal_classifier_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Numeric literal classifier checker
// Watches both channels, predicts the format code of every literal from the
// characters that transfer, and compares each result transfer in order.
// ----------------------------------------------------------------------------

module numeric_literal_classifier_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] char_code,
	input  logic       last_char,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [2:0] format_code,
	output int         fail_count,
	output int         pending
);
	import nlc_pkg::*;

	localparam int REPORT_MAX = 10;

	logic [1:0] n_seen;
	logic       lead_zero;
	prefix_t    pfx;
	logic       has_dot;
	logic       dec_good;
	logic       oct_good;
	logic       hex_good;
	logic       bin_good;
	logic       flt_good;
	phase_t     dot_phase;

	fmt_t expected_formats[$];

	initial begin
		fail_count = 0;
		pending = 0;
	end

	task automatic clear_literal();
		n_seen = '0;
		lead_zero = 1'b0;
		pfx = PK_NONE;
		has_dot = 1'b0;
		dec_good = 1'b1;
		oct_good = 1'b1;
		hex_good = 1'b1;
		bin_good = 1'b1;
		flt_good = 1'b1;
		dot_phase = PH_IDLE;
	endtask

	task automatic classify_char(input logic [7:0] c, input logic fin);
		logic digit;
		logic octd;
		logic hexd;
		logic bad;
		fmt_t code;
		digit = (c >= CH_0) && (c <= CH_9);
		octd = (c >= CH_0) && (c <= CH_7);
		hexd = digit || ((c >= CH_LC_A) && (c <= CH_LC_F)) ||
			((c >= CH_UC_A) && (c <= CH_UC_F));
		bad = 1'b0;

		if (!digit)
			dec_good = 1'b0;
		if (n_seen == 2'd0) begin
			lead_zero = (c == CH_0);
		end else if (n_seen == 2'd1 && lead_zero) begin
			if (c == CH_LC_X || c == CH_UC_X)
				pfx = PK_HEX;
			else if (c == CH_LC_B || c == CH_UC_B)
				pfx = PK_BINARY;
			else
				pfx = PK_OCTAL;
		end
		if (n_seen != 2'd0 && !octd)
			oct_good = 1'b0;
		if (n_seen == POS_MAX) begin
			if (!hexd)
				hex_good = 1'b0;
			if (c != CH_0 && c != CH_1)
				bin_good = 1'b0;
		end

		if (c == CH_DOT)
			has_dot = 1'b1;
		if (!(digit || c == CH_DOT || c == CH_PLUS || c == CH_MINUS ||
				c == CH_LC_E || c == CH_UC_E))
			flt_good = 1'b0;

		case (dot_phase)
			PH_NEED_DIGIT: begin
				bad = !digit;
				dot_phase = digit ? PH_DIGITS : PH_IDLE;
			end
			PH_DIGITS: begin
				if (digit)
					dot_phase = PH_DIGITS;
				else if (c == CH_LC_E || c == CH_UC_E)
					dot_phase = PH_AFTER_EXP;
				else if (c == CH_DOT)
					dot_phase = PH_NEED_DIGIT;
				else
					dot_phase = PH_IDLE;
			end
			PH_AFTER_EXP: begin
				if (c == CH_PLUS || c == CH_MINUS) begin
					dot_phase = PH_AFTER_SIGN;
				end else begin
					bad = !digit;
					dot_phase = PH_IDLE;
				end
			end
			PH_AFTER_SIGN: begin
				bad = !digit;
				dot_phase = PH_IDLE;
			end
			default: begin
				dot_phase = (c == CH_DOT) ? PH_NEED_DIGIT : PH_IDLE;
			end
		endcase
		if (bad)
			flt_good = 1'b0;

		if (fin) begin
			if (n_seen == 2'd0)
				code = digit ? FMT_DECIMAL : FMT_INVALID;
			else if (has_dot)
				code = (flt_good && (dot_phase == PH_IDLE || dot_phase == PH_DIGITS)) ?
					FMT_FLOAT : FMT_INVALID;
			else if (lead_zero)
				case (pfx)
					PK_HEX:    code = hex_good ? FMT_HEX : FMT_INVALID;
					PK_BINARY: code = bin_good ? FMT_BINARY : FMT_INVALID;
					default:   code = oct_good ? FMT_OCTAL : FMT_INVALID;
				endcase
			else
				code = dec_good ? FMT_DECIMAL : FMT_INVALID;
			expected_formats.push_back(code);
			clear_literal();
		end else if (n_seen != POS_MAX) begin
			n_seen = n_seen + 2'd1;
		end
	endtask

	task automatic check_format(input logic [2:0] got);
		fmt_t want;
		if (expected_formats.size() == 0) begin
			if (fail_count < REPORT_MAX)
				$display("%0t: format_code %0d transfer with none expected", $realtime, got);
			fail_count++;
		end else begin
			want = expected_formats.pop_front();
			if (got !== want) begin
				if (fail_count < REPORT_MAX)
					$display("%0t: format_code expected %0d (%s) got %0d", $realtime,
						want, want.name(), got);
				fail_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_literal();
			expected_formats.delete();
		end else begin
			if (out_valid && !out_stall)
				check_format(format_code);
			if (in_valid && !in_stall)
				classify_char(char_code, last_char);
		end
		pending = expected_formats.size();
	end

endmodule

// ===== tb/numeric_literal_classifier_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Numeric literal classifier testbench
// Streams directed and random literals of every format, well-formed and
// broken, with random idle bursts on both channels, and reports the verdict.
// ----------------------------------------------------------------------------

module numeric_literal_classifier_tb;
	import nlc_pkg::*;

	localparam int CHAR_TARGET    = 1400;
	localparam int QUIET_FROM     = 1200;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 8;

	typedef enum int {
		LK_DECIMAL,
		LK_OCTAL,
		LK_HEX,
		LK_BINARY,
		LK_FLOAT
	} lit_kind_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] char_code;
	logic       last_char;
	logic       out_valid;
	logic       out_stall;
	logic [2:0] format_code;

	int fail_count;
	int pending;

	logic       tx_idle_en;
	logic       rx_idle_en;
	int         stall_left;
	int         quiet_cycles = 0;
	int         chars_sent = 0;
	logic [7:0] literal_chars[$];

	numeric_literal_classifier u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.char_code  (char_code),
		.last_char  (last_char),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.format_code(format_code)
	);

	numeric_literal_classifier_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.char_code  (char_code),
		.last_char  (last_char),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.format_code(format_code),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(0, 4);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_char(input logic [7:0] c, input logic fin);
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_code <= c;
		last_char <= fin;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_literal();
		for (int i = 0; i < literal_chars.size(); i++)
			send_char(literal_chars[i], i == literal_chars.size() - 1);
		chars_sent += literal_chars.size();
		literal_chars.delete();
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			literal_chars.push_back(s[i]);
	endtask

	task automatic add_digits(input int n, input logic [7:0] hi);
		repeat (n) literal_chars.push_back(8'(CH_0 + $urandom_range(0, hi - CH_0)));
	endtask

	task automatic add_hex_digits(input int n);
		repeat (n) begin
			if ($urandom_range(0, 1))
				literal_chars.push_back(8'(CH_0 + $urandom_range(0, 9)));
			else
				literal_chars.push_back(8'(($urandom_range(0, 1) ? CH_LC_A : CH_UC_A) +
					$urandom_range(0, 5)));
		end
	endtask

	task automatic build_literal(input lit_kind_t kind);
		case (kind)
			LK_DECIMAL: begin
				literal_chars.push_back(8'(CH_1 + $urandom_range(0, 8)));
				add_digits($urandom_range(0, 5), CH_9);
			end
			LK_OCTAL: begin
				literal_chars.push_back(CH_0);
				add_digits($urandom_range(1, 5), CH_7);
			end
			LK_HEX: begin
				literal_chars.push_back(CH_0);
				literal_chars.push_back($urandom_range(0, 1) ? CH_LC_X : CH_UC_X);
				add_hex_digits($urandom_range(0, 5));
			end
			LK_BINARY: begin
				literal_chars.push_back(CH_0);
				literal_chars.push_back($urandom_range(0, 1) ? CH_LC_B : CH_UC_B);
				add_digits($urandom_range(0, 6), CH_1);
			end
			default: begin
				add_digits($urandom_range(0, 3), CH_9);
				repeat ($urandom_range(1, 2)) begin
					literal_chars.push_back(CH_DOT);
					add_digits($urandom_range(1, 3), CH_9);
					if ($urandom_range(0, 1)) begin
						literal_chars.push_back($urandom_range(0, 1) ? CH_LC_E : CH_UC_E);
						if ($urandom_range(0, 1))
							literal_chars.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
						add_digits($urandom_range(1, 2), CH_9);
					end
				end
			end
		endcase
	endtask

	task automatic corrupt_literal();
		int pos;
		pos = $urandom_range(0, literal_chars.size() - 1);
		case ($urandom_range(0, 2))
			0: literal_chars[pos] = 8'($urandom_range(0, 255));
			1: begin
				case ($urandom_range(0, 5))
					0: literal_chars[pos] = CH_DOT;
					1: literal_chars[pos] = CH_LC_E;
					2: literal_chars[pos] = CH_PLUS;
					3: literal_chars[pos] = CH_9;
					4: literal_chars[pos] = CH_UC_X;
					default: literal_chars[pos] = CH_UC_B;
				endcase
			end
			default: begin
				if (literal_chars.size() > 1)
					void'(literal_chars.pop_back());
				else
					literal_chars[pos] = 8'($urandom_range(0, 255));
			end
		endcase
	endtask

	initial begin
		int sel;
		int n_lit;
		arst_n = 1'b0;
		in_valid = 1'b0;
		char_code = '0;
		last_char = 1'b0;
		out_stall = 1'b0;
		stall_left = 0;
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		n_lit = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// single characters, bare prefixes, short forms, dot rules
		push_text("7");
		send_literal();
		push_text(".");
		send_literal();
		literal_chars.push_back(8'hff);
		send_literal();
		literal_chars.push_back(8'h00);
		send_literal();
		push_text("0x");
		send_literal();
		push_text("0B");
		send_literal();
		push_text("07");
		send_literal();
		push_text("12");
		send_literal();
		push_text("1.5e+3");
		send_literal();
		push_text("3.");
		send_literal();
		push_text("0XfF");
		send_literal();

		while (chars_sent < CHAR_TARGET) begin
			if (chars_sent >= QUIET_FROM) begin
				tx_idle_en = 1'b0;
				rx_idle_en = 1'b0;
			end else if (n_lit % 25 == 0) begin
				tx_idle_en = ($urandom_range(0, 3) != 0);
				rx_idle_en = ($urandom_range(0, 3) != 0);
			end
			sel = $urandom_range(0, 19);
			if (sel < 15) begin
				build_literal(lit_kind_t'(sel / 3));
			end else if (sel < 18) begin
				build_literal(lit_kind_t'($urandom_range(0, 4)));
				corrupt_literal();
			end else begin
				repeat ($urandom_range(1, 6))
					literal_chars.push_back(8'($urandom_range(0, 255)));
			end
			send_literal();
			n_lit++;
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
